@@ hw/rtl/pbgd_pkg.sv @@
package pbgd_pkg;

	// Parameter defaults
	localparam int PIXEL_BITS_DEF      = 12;
	localparam int ANGLE_FRAC_BITS_DEF = 13;
	localparam int CORDIC_STAGES_DEF   = 16;

	// Field widths
	localparam int PIX_W   = 12;
	localparam int FOCAL_W = 16;
	localparam int HGT_W   = 12;
	localparam int ANG_W   = 16;
	localparam int DIST_W  = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	// Datapath widths: vectoring lanes, rotation lanes, angle accumulator, wide angle sums
	localparam int VEC_W  = 28;
	localparam int ROT_W  = 33;
	localparam int Z_W    = 35;
	localparam int WIDE_W = 36;

	localparam int TAB_LEN = 24;

	// atan(2^-i) in radians, 32 fraction bits
	localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
		32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
		32'd1048576,    32'd524288,     32'd262144,     32'd131072,
		32'd65536,      32'd32768,      32'd16384,      32'd8192,
		32'd4096,       32'd2048,       32'd1024,       32'd512
	};

	// Register map
	typedef enum logic [IDX_W-1:0] {
		REG_FOCAL_X   = 3'd0,
		REG_FOCAL_Y   = 3'd1,
		REG_CENTER_X  = 3'd2,
		REG_CENTER_Y  = 3'd3,
		REG_CAM_HGT   = 3'd4
	} reg_idx_t;

	// Result carried alongside the distance path
	typedef struct packed {
		logic signed [ANG_W-1:0] pan;
		logic signed [ANG_W-1:0] tilt;
		logic                    dv;
		logic                    go;
	} res_t;

	typedef struct packed {
		res_t r;
		logic sat;
	} div_side_t;

	function automatic logic signed [ANG_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(32767);
		lo = -WIDE_W'(32768);
		if (v > hi) return ANG_W'(32767);
		if (v < lo) return -ANG_W'(32768);
		return v[ANG_W-1:0];
	endfunction

endpackage

@@ hw/rtl/pbgd_cordic.sv @@
// Pipelined CORDIC, one micro-rotation per register stage.
// VECTORING=1 drives y to zero, otherwise drives z to zero.
module pbgd_cordic
	import pbgd_pkg::*;
#(
	parameter int NST       = CORDIC_STAGES_DEF,
	parameter int XW        = VEC_W,
	parameter bit VECTORING = 1'b1
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [XW-1:0]  x_in,
	input  logic signed [XW-1:0]  y_in,
	input  logic signed [Z_W-1:0] z_in,
	output logic signed [XW-1:0]  x_out,
	output logic signed [XW-1:0]  y_out,
	output logic signed [Z_W-1:0] z_out
);

	logic signed [XW-1:0]  x_s [NST];
	logic signed [XW-1:0]  y_s [NST];
	logic signed [Z_W-1:0] z_s [NST];

	for (genvar i = 0; i < NST; i++) begin : g_st
		logic signed [XW-1:0]  xc;
		logic signed [XW-1:0]  yc;
		logic signed [Z_W-1:0] zc;
		logic signed [Z_W-1:0] ang;
		logic                  pos;

		if (i == 0) begin : g_first
			assign xc = x_in;
			assign yc = y_in;
			assign zc = z_in;
		end else begin : g_next
			assign xc = x_s[i-1];
			assign yc = y_s[i-1];
			assign zc = z_s[i-1];
		end

		assign ang = $signed(Z_W'(ATAN_TAB[i]));
		// vectoring turns on the sign of y, rotation on the sign of z
		assign pos = VECTORING ? (yc >= 0) : (zc < 0);

		always_ff @(posedge clk) begin
			if (en) begin
				if (pos) begin
					x_s[i] <= xc + (yc >>> i);
					y_s[i] <= yc - (xc >>> i);
					z_s[i] <= zc + ang;
				end else begin
					x_s[i] <= xc - (yc >>> i);
					y_s[i] <= yc + (xc >>> i);
					z_s[i] <= zc - ang;
				end
			end
		end
	end

	assign x_out = x_s[NST-1];
	assign y_out = y_s[NST-1];
	assign z_out = z_s[NST-1];

endmodule

@@ hw/rtl/pbgd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The dividend must be below den << QW.
module pbgd_div
	import pbgd_pkg::*;
#(
	parameter int DW = 32,
	parameter int QW = DIST_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DW+QW-1:0] num_in,
	input  logic [DW-1:0]    den_in,
	output logic [QW-1:0]    q_out
);

	localparam int RW = DW + QW;

	logic [RW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [RW-1:0] rc;
		logic [DW-1:0] dc;
		logic [QW-1:0] qc;
		logic [RW-1:0] sub;
		logic          take;

		if (k == 0) begin : g_first
			assign rc = num_in;
			assign dc = den_in;
			assign qc = '0;
		end else begin : g_next
			assign rc = rem_s[k-1];
			assign dc = den_s[k-1];
			assign qc = q_s[k-1];
		end

		assign sub  = RW'(dc) << (QW - 1 - k);
		assign take = (rc >= sub);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? (rc - sub) : rc;
				den_s[k] <= dc;
				q_s[k]   <= {qc[QW-2:0], take};
			end
		end
	end

	assign q_out = q_s[QW-1];

endmodule

@@ hw/rtl/pixel_to_bearing_and_ground_distance_core.sv @@
// Turns a detected target's pixel position plus head pan/tilt into absolute
// pan and tilt angles (signed radians, ANGLE_FRAC_BITS fraction bits) and a
// ground range in mm (camera height times cot(tilt), rounded, saturated at
// 65535; 0 with distance_valid low when tilt is not positive, 0 with
// distance_valid high when tilt reaches pi/2). A beat can be taken every
// cycle while the pipeline is not frozen. With N = min(CORDIC_STAGES, 24)
// it has one input stage, N vectoring CORDIC stages, an angle add stage, N
// rotation CORDIC stages, a multiply stage, a dividend stage and a 16-stage
// divider. When out_stall holds back a waiting result the whole pipeline
// freezes and in_stall rises in the same cycle. Configuration writes take
// effect immediately and should be made while no beat is in flight.
module pixel_to_bearing_and_ground_distance_core
	import pbgd_pkg::*;
#(
	parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [PIX_W-1:0]         target_col,
	input  logic [PIX_W-1:0]         target_row,
	input  logic signed [ANG_W-1:0]  base_pan,
	input  logic signed [ANG_W-1:0]  base_tilt,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [ANG_W-1:0]  bearing_pan,
	output logic signed [ANG_W-1:0]  bearing_tilt,
	output logic [DIST_W-1:0]        ground_distance_mm,
	output logic                     distance_valid
);

	localparam int NST = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
	localparam int SH  = 32 - ANGLE_FRAC_BITS;
	localparam logic [PIX_W-1:0] PixMask =
		(PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << PIXEL_BITS) - 1);
	localparam logic signed [Z_W-1:0] RndHalf = Z_W'(64'd1 << (SH - 1));
	localparam longint HalfPiL = (64'd6746518852 + (64'd1 << (SH - 1))) >> SH;
	localparam logic signed [WIDE_W-1:0] HalfPi = WIDE_W'(HalfPiL);
	localparam int DDW = 32;
	localparam int RW  = DDW + DIST_W;

	// Global advance: move unless a result waits on a stalled output
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Configuration registers
	logic [FOCAL_W-1:0] focal_x_q, focal_y_q;
	logic [PIX_W-1:0]   center_x_q, center_y_q;
	logic [HGT_W-1:0]   cam_hgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_W'(8960);
			focal_y_q  <= FOCAL_W'(8960);
			center_x_q <= PIX_W'(320);
			center_y_q <= PIX_W'(240);
			cam_hgt_q  <= HGT_W'(500);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FOCAL_X:  focal_x_q  <= cfg_wdata;
				REG_FOCAL_Y:  focal_y_q  <= cfg_wdata;
				REG_CENTER_X: center_x_q <= cfg_wdata[PIX_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg_wdata[PIX_W-1:0];
				REG_CAM_HGT:  cam_hgt_q  <= cfg_wdata[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: offsets from image center
	logic                    valid_s1;
	logic signed [PIX_W:0]   dx_s1, dy_s1;
	logic signed [ANG_W-1:0] hp_s1, ht_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({1'b0, target_col & PixMask}) -
				$signed({1'b0, center_x_q & PixMask});
			dy_s1 <= $signed({1'b0, target_row & PixMask}) -
				$signed({1'b0, center_y_q & PixMask});
			hp_s1 <= base_pan;
			ht_s1 <= base_tilt;
		end
	end

	// Vectoring CORDICs for atan(16*dx/fx) and atan(16*dy/fy)
	logic signed [VEC_W-1:0] vx_unused_x, vy_unused_x, vx_unused_y, vy_unused_y;
	logic signed [Z_W-1:0]   zx, zy;

	pbgd_cordic #(.NST(NST), .XW(VEC_W), .VECTORING(1'b1)) u_atan_x (
		.clk   (clk),
		.en    (en),
		.x_in  ($signed(VEC_W'({focal_x_q, 8'd0}))),
		.y_in  (VEC_W'($signed({dx_s1, 12'd0}))),
		.z_in  ('0),
		.x_out (vx_unused_x),
		.y_out (vy_unused_x),
		.z_out (zx)
	);

	pbgd_cordic #(.NST(NST), .XW(VEC_W), .VECTORING(1'b1)) u_atan_y (
		.clk   (clk),
		.en    (en),
		.x_in  ($signed(VEC_W'({focal_y_q, 8'd0}))),
		.y_in  (VEC_W'($signed({dy_s1, 12'd0}))),
		.z_in  ('0),
		.x_out (vx_unused_y),
		.y_out (vy_unused_y),
		.z_out (zy)
	);

	// Head angles and valid ride along the vectoring pipeline
	logic                    vv_q  [NST];
	logic signed [ANG_W-1:0] hp_dl_q [NST];
	logic signed [ANG_W-1:0] ht_dl_q [NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) vv_q[k] <= 1'b0;
		end else if (en) begin
			vv_q[0] <= valid_s1;
			for (int k = 1; k < NST; k++) vv_q[k] <= vv_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hp_dl_q[0] <= hp_s1;
			ht_dl_q[0] <= ht_s1;
			for (int k = 1; k < NST; k++) begin
				hp_dl_q[k] <= hp_dl_q[k-1];
				ht_dl_q[k] <= ht_dl_q[k-1];
			end
		end
	end

	// Stage 2: round offset angles, add head angles, saturate
	logic signed [Z_W-1:0]    rx, ry;
	logic signed [WIDE_W-1:0] pan_w, tilt_w;
	logic signed [ANG_W-1:0]  tilt_c;
	logic                     valid_s2;
	res_t                     res_s2;

	assign rx     = (zx + RndHalf) >>> SH;
	assign ry     = (zy + RndHalf) >>> SH;
	assign pan_w  = WIDE_W'(hp_dl_q[NST-1]) + WIDE_W'(rx);
	assign tilt_w = WIDE_W'(ht_dl_q[NST-1]) + WIDE_W'(ry);
	assign tilt_c = sat16(tilt_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= vv_q[NST-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.pan  <= sat16(pan_w);
			res_s2.tilt <= tilt_c;
			res_s2.dv   <= (tilt_c > 0);
			res_s2.go   <= (tilt_c > 0) && (WIDE_W'(tilt_c) < HalfPi);
		end
	end

	// Rotation CORDIC for scaled cos and sin of tilt
	logic signed [ROT_W-1:0] cos_v, sin_v;
	logic signed [Z_W-1:0]   z_rest_unused;

	pbgd_cordic #(.NST(NST), .XW(ROT_W), .VECTORING(1'b0)) u_rot (
		.clk   (clk),
		.en    (en),
		.x_in  ($signed(ROT_W'(64'd1 << 30))),
		.y_in  ('0),
		.z_in  (Z_W'(res_s2.tilt) <<< SH),
		.x_out (cos_v),
		.y_out (sin_v),
		.z_out (z_rest_unused)
	);

	logic rv_q   [NST];
	res_t res_dl_q [NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) rv_q[k] <= 1'b0;
		end else if (en) begin
			rv_q[0] <= valid_s2;
			for (int k = 1; k < NST; k++) rv_q[k] <= rv_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_dl_q[0] <= res_s2;
			for (int k = 1; k < NST; k++) res_dl_q[k] <= res_dl_q[k-1];
		end
	end

	// Stage 3: height times clamped cosine
	logic                       valid_s3;
	res_t                       res_s3;
	logic [HGT_W+DDW-1:0]       num_s3;
	logic [DDW-1:0]             sin_s3;
	logic                       sneg_s3;
	logic [DDW-1:0]             cpos;

	assign cpos = (cos_v > 0) ? cos_v[DDW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= rv_q[NST-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3  <= res_dl_q[NST-1];
			num_s3  <= cam_hgt_q * cpos;
			sin_s3  <= sin_v[DDW-1:0];
			sneg_s3 <= (sin_v <= 0);
		end
	end

	// Stage 4: rounding bias and overflow check of the quotient
	logic          valid_s4;
	div_side_t     side_s4;
	logic [RW-1:0] n_s4;
	logic [DDW-1:0] den_s4;
	logic [RW-1:0] n_c;

	assign n_c = RW'(num_s3) + RW'(sin_s3 >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else if (en) valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.r   <= res_s3;
			side_s4.sat <= sneg_s3 || (n_c >= {sin_s3, {DIST_W{1'b0}}});
			n_s4        <= n_c;
			den_s4      <= sin_s3;
		end
	end

	// Divider
	logic [DIST_W-1:0] quot;

	pbgd_div #(.DW(DDW), .QW(DIST_W)) u_div (
		.clk    (clk),
		.en     (en),
		.num_in (n_s4),
		.den_in (den_s4),
		.q_out  (quot)
	);

	logic      dv_q   [DIST_W];
	div_side_t dside_q [DIST_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIST_W; k++) dv_q[k] <= 1'b0;
		end else if (en) begin
			dv_q[0] <= valid_s4;
			for (int k = 1; k < DIST_W; k++) dv_q[k] <= dv_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside_q[0] <= side_s4;
			for (int k = 1; k < DIST_W; k++) dside_q[k] <= dside_q[k-1];
		end
	end

	// Output beat
	div_side_t fin;
	assign fin          = dside_q[DIST_W-1];
	assign out_valid    = dv_q[DIST_W-1];
	assign bearing_pan  = fin.r.pan;
	assign bearing_tilt = fin.r.tilt;
	assign distance_valid = fin.r.dv;
	assign ground_distance_mm = !fin.r.go ? '0 : (fin.sat ? '1 : quot);

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import pbgd_pkg::*;

	localparam int NSTG = 16;
	localparam int LATENCY = 2 * NSTG + 20;
	localparam int HALF_NS = 4;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [PIX_W-1:0]        col;
		logic [PIX_W-1:0]        row;
		logic signed [ANG_W-1:0] pan;
		logic signed [ANG_W-1:0] tilt;
	} target_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] pan;
		logic signed [ANG_W-1:0] tilt;
		logic [DIST_W-1:0]       range_mm;
		logic                    dv;
	} bearing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] target_col = '0;
	logic [PIX_W-1:0] target_row = '0;
	logic signed [ANG_W-1:0] base_pan = '0;
	logic signed [ANG_W-1:0] base_tilt = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ANG_W-1:0] bearing_pan;
	logic signed [ANG_W-1:0] bearing_tilt;
	logic [DIST_W-1:0] ground_distance_mm;
	logic distance_valid;

	// camera setup as the predictor sees it
	longint fx, fy, cx, cy, cam_h;

	target_t  pending_targets[$];
	bearing_t expected_bearings[$];
	int  n_errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_valid_dist = 0;
	int  idle_cycles = 0;
	logic in_taken = 1'b0;
	bit  hold_off = 1'b0;
	int  hold_left = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;

	always #(HALF_NS) clk = ~clk;

	pixel_to_bearing_and_ground_distance_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.target_col(target_col), .target_row(target_row),
		.base_pan(base_pan), .base_tilt(base_tilt),
		.out_valid(out_valid), .out_stall(out_stall),
		.bearing_pan(bearing_pan), .bearing_tilt(bearing_tilt),
		.ground_distance_mm(ground_distance_mm), .distance_valid(distance_valid)
	);

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint to_angle(longint z32);
		return shr_floor(z32 + (64'sd1 <<< (31 - 13)), 32 - 13);
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// vectoring pass: angle of (x, y) with 32 fraction bits
	function automatic longint offset_angle(longint x, longint y);
		longint z, xs, ys;
		z = 0;
		for (int i = 0; i < NSTG; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += longint'(ATAN_TAB[i]);
			end else begin
				x = x - ys; y = y + xs; z -= longint'(ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic bearing_t predict_bearing(target_t t);
		bearing_t b;
		longint dx, dy, phi, beta, pan, tilt, half_pi, x, y, z, xs, ys, num, q;
		dx = longint'(t.col) - cx;
		dy = longint'(t.row) - cy;
		phi = to_angle(offset_angle(fx * 256, dx * 4096));
		beta = to_angle(offset_angle(fy * 256, dy * 4096));
		pan = clip16(longint'(t.pan) + phi);
		tilt = clip16(longint'(t.tilt) + beta);
		half_pi = to_angle(longint'(ATAN_TAB[0]) * 2);
		b.pan = pan[15:0];
		b.tilt = tilt[15:0];
		b.dv = tilt > 0;
		b.range_mm = '0;
		if (b.dv && tilt < half_pi) begin
			// rotation pass gives scaled cos and sin of the tilt
			x = 64'sd1 <<< 30; y = 0; z = tilt * (64'sd1 <<< 19);
			for (int i = 0; i < NSTG; i++) begin
				xs = shr_floor(x, i);
				ys = shr_floor(y, i);
				if (z >= 0) begin
					x = x - ys; y = y + xs; z -= longint'(ATAN_TAB[i]);
				end else begin
					x = x + ys; y = y - xs; z += longint'(ATAN_TAB[i]);
				end
			end
			if (y <= 0) b.range_mm = 16'hFFFF;
			else begin
				num = cam_h * (x > 0 ? x : 64'sd0);
				q = (num + y / 2) / y;
				b.range_mm = q > 65535 ? 16'hFFFF : q[15:0];
			end
		end
		return b;
	endfunction

	// driver: offers the next pending target at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_targets.size() > 0) begin
					target_t t;
					t = pending_targets.pop_front();
					target_col <= t.col;
					target_row <= t.row;
					base_pan <= t.pan;
					base_tilt <= t.tilt;
					in_valid <= 1'b1;
					tx_gap = ($urandom_range(0, 9) < 7) ? 0 :
						(($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
						$urandom_range(10, 40));
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls: random gaps plus a single long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_off) begin
				hold_off = 1'b0;
				hold_left = 200;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				rx_gap = ($urandom_range(0, 9) < 7) ? 0 :
					(($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
					$urandom_range(10, 40));
			end
		end
	end

	// monitor: records input beats, checks each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_bearings.push_back(predict_bearing(
					{target_col, target_row, base_pan, base_tilt}));
				n_sent++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_bearings.size() == 0) begin
					$error("result beat with no expectation pending");
					n_errors++;
				end else begin
					bearing_t e;
					e = expected_bearings.pop_front();
					n_checked++;
					if (distance_valid) n_valid_dist++;
					if (bearing_pan !== e.pan) begin
						$error("bearing_pan exp %0d got %0d", e.pan, bearing_pan);
						n_errors++;
					end
					if (bearing_tilt !== e.tilt) begin
						$error("bearing_tilt exp %0d got %0d", e.tilt, bearing_tilt);
						n_errors++;
					end
					if (ground_distance_mm !== e.range_mm) begin
						$error("ground_distance_mm exp %0d got %0d", e.range_mm,
							ground_distance_mm); n_errors++;
					end
					if (distance_valid !== e.dv) begin
						$error("distance_valid exp %0d got %0d", e.dv, distance_valid);
						n_errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FOCAL_X: fx = longint'(val & 32'hFFFF);
			REG_FOCAL_Y: fy = longint'(val & 32'hFFFF);
			REG_CENTER_X: cx = longint'(val & 32'hFFF);
			REG_CENTER_Y: cy = longint'(val & 32'hFFF);
			REG_CAM_HGT: cam_h = longint'(val & 32'hFFF);
			default: ;
		endcase
	endtask

	task automatic add_target(int col, int row, int pan, int tilt);
		target_t t;
		t.col = PIX_W'(col); t.row = PIX_W'(row);
		t.pan = ANG_W'(pan); t.tilt = ANG_W'(tilt);
		pending_targets.push_back(t);
	endtask

	// random target; mostly near the image center with realistic head angles
	task automatic add_random_target();
		if ($urandom_range(0, 3) == 0)
			add_target($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 65535), $urandom_range(0, 65535));
		else
			add_target(int'(cx) + int'($urandom_range(0, 800)) - 400,
				int'(cy) + int'($urandom_range(0, 600)) - 300,
				int'($urandom_range(0, 16000)) - 8000,
				int'($urandom_range(0, 14000)) - 2000);
	endtask

	task automatic drain();
		while (pending_targets.size() > 0 || in_valid || expected_bearings.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		fx = 8960; fy = 8960; cx = 320; cy = 240; cam_h = 500;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, non-positive tilt, steep tilt, tiny tilt
		add_target(320, 240, 0, 0);
		add_target(320, 240, 0, 1);
		add_target(320, 240, 0, 2000);
		add_target(320, 240, 0, 12867);
		add_target(320, 240, 0, 20000);
		add_target(320, 240, 0, -1);
		add_target(0, 0, -32768, -32768);
		add_target(4095, 4095, 32767, 32767);
		add_target(0, 4095, 32767, 32000);
		add_target(4095, 0, -32768, 5000);
		add_target(640, 480, 100, 3000);
		add_target(320, 240, 32767, 32767);
		add_target(320, 240, -32768, -32768);
		add_target(2730, 1365, 21845, 10922);
		add_target(1365, 2730, -21846, 300);
		drain();

		// phase settings: extremes of each register, zero focal included, then random settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_FOCAL_X, 16); write_reg(REG_FOCAL_Y, 16);
					write_reg(REG_CENTER_X, 0); write_reg(REG_CENTER_Y, 0);
					write_reg(REG_CAM_HGT, 0);
				end
				1: begin
					write_reg(REG_FOCAL_X, 65535); write_reg(REG_FOCAL_Y, 65535);
					write_reg(REG_CENTER_X, 4095); write_reg(REG_CENTER_Y, 4095);
					write_reg(REG_CAM_HGT, 4095);
				end
				2: begin
					write_reg(REG_FOCAL_X, 0); write_reg(REG_FOCAL_Y, 0);
					write_reg(REG_CENTER_X, 2048); write_reg(REG_CENTER_Y, 2048);
					write_reg(REG_CAM_HGT, 1);
				end
				default: begin
					write_reg(REG_FOCAL_X, $urandom_range(16, 65535));
					write_reg(REG_FOCAL_Y, $urandom_range(16, 65535));
					write_reg(REG_CENTER_X, $urandom_range(0, 4095));
					write_reg(REG_CENTER_Y, $urandom_range(0, 4095));
					write_reg(REG_CAM_HGT, $urandom_range(0, 4095));
				end
			endcase
			if (ph == 3) hold_off = 1'b1;
			for (int k = 0; k < 200; k++) add_random_target();
			if (ph == 2) begin
				add_target(2048, 2048, 0, 0);
				add_target(2048, 2049, 0, 0);
			end
			drain();
		end

		$display("Sent %0d targets and checked %0d bearing results over 7 camera setups,",
			n_sent, n_checked);
		$display("%0d of them with a valid distance, including one long receiver hold-off.",
			n_valid_dist);
		if (n_errors == 0 && expected_bearings.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
